FILE: hdl/fss_pkg.sv
// Package for the fuzzy subsequence scorer: opcode type, scoring constants,
// separator code points, the 16-bit saturation helper and is_sep. No dependencies.
`timescale 1ns / 1ps

package fss_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } t_opcode;

    // Scoring constants
    localparam int SCORE_START   = 1000;
    localparam int BONUS_ADJ     = 18;
    localparam int GAP_CAP       = 40;
    localparam int BONUS_BOUND   = 12;
    localparam int LEAD_CAP      = 80;
    localparam int EXTRA_CAP     = 120;

    // Separator code points
    localparam logic [20:0] CP_SPACE = 21'h20;
    localparam logic [20:0] CP_SLASH = 21'h2F;
    localparam logic [20:0] CP_DASH  = 21'h2D;
    localparam logic [20:0] CP_UNDER = 21'h5F;
    localparam logic [20:0] CP_DOT   = 21'h2E;

    // Saturate an 18-bit signed sum to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    function automatic logic is_sep(input logic [20:0] c);
        return (c == CP_SPACE) || (c == CP_SLASH) || (c == CP_DASH) ||
               (c == CP_UNDER) || (c == CP_DOT);
    endfunction

endpackage

FILE: hdl/fuzzy_subsequence_score_top.sv
// Results are registered, in the skid while the output stalls. Throughput: one
// input word per cycle while o_in_stall is low; the query character for the next
// compare is prefetched from the query memory's registered read port, so a match
// and the following compare never wait on each other. A two-entry output (register
// + skid) keeps the input moving while a result waits. Synchronous active-low
// reset clears the query length and scan state; the query memory is not cleared.
`timescale 1ns / 1ps

module fuzzy_subsequence_score_top
    import fss_pkg::*;
#(
    parameter int QUERY_MAX = 512,
    parameter int TEXT_MAX  = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [20:0]        i_code_point,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_found,
    output logic signed [15:0] o_score,
    output logic               o_overflow
);

    localparam int AW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
    localparam int CW = $clog2(QUERY_MAX + 1);
    localparam int PW = $clog2(TEXT_MAX + 1);
    localparam int LW = PW + 1;
    localparam int GW = PW + 2;
    localparam int XW = ((PW > CW) ? PW : CW) + 1;

    // Query memory and prefetched character
    logic [20:0] mem [QUERY_MAX];
    logic [20:0] r_qchar;

    // Scan state
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_slot, n_slot;
    logic [PW-1:0]        r_pos, n_pos;
    logic signed [LW-1:0] r_last, n_last;
    logic signed [15:0]   r_score, n_score;
    logic                 r_sep, n_sep;
    logic                 r_sat, n_sat;

    // Output register and skid
    logic               r_out_valid, r_sk_valid;
    logic               r_found, r_sk_found;
    logic signed [15:0] r_oscore, r_sk_score;
    logic               r_ovf, r_sk_ovf;

    logic               accept;
    logic               wr_en;
    t_opcode            op;
    logic               res_en;
    logic               res_found;
    logic signed [15:0] res_score;

    // Text step intermediates
    logic [PW-1:0]        pos;
    logic                 match;
    logic signed [GW-1:0] span;
    logic [5:0]           gap;
    logic [6:0]           lead;
    logic signed [17:0]   s;
    logic [XW-1:0]        extra;
    logic [6:0]           extra_cap;
    logic [4:0]           extra_q;
    logic                 out_free;

    assign accept     = i_in_valid && !r_sk_valid;
    assign o_in_stall = r_sk_valid;
    assign op         = t_opcode'(i_opcode);
    assign wr_en      = accept && (op == OP_APPEND) && (r_count < CW'(QUERY_MAX));

    // Next scan state and end-of-text result
    always_comb begin
        n_count   = r_count;
        n_slot    = r_slot;
        n_pos     = r_pos;
        n_last    = r_last;
        n_score   = r_score;
        n_sep     = r_sep;
        n_sat     = r_sat;
        res_en    = 1'b0;
        res_found = 1'b0;
        res_score = '0;

        pos       = (r_pos >= PW'(TEXT_MAX)) ? PW'(TEXT_MAX) : r_pos;
        match     = (r_slot < r_count) && (r_qchar == i_code_point);
        span      = $signed({2'b00, pos}) - GW'(r_last) - GW'(1);
        if (span < 0) begin
            gap = '0;
        end else if (span > GW'(GAP_CAP)) begin
            gap = 6'(GAP_CAP);
        end else begin
            gap = 6'(span);
        end
        lead      = (int'(pos) > LEAD_CAP) ? 7'(LEAD_CAP) : 7'(pos);
        s         = 18'(r_score);
        if (span == 0) begin
            s = s + 18'(BONUS_ADJ);
        end else begin
            s = s - 18'(gap);
        end
        if (r_sep) begin
            s = s + 18'(BONUS_BOUND);
        end
        if (r_slot == '0) begin
            s = s - 18'(lead);
        end

        extra     = XW'(r_pos) - XW'(r_count);
        extra_cap = (int'(extra) > EXTRA_CAP) ? 7'(EXTRA_CAP) : 7'(extra);
        extra_q   = extra_cap[6:2];

        if (accept) begin
            unique case (op)
                OP_CLEAR: begin
                    n_count = '0;
                end
                OP_APPEND: begin
                    if (wr_en) begin
                        n_count = r_count + CW'(1);
                    end
                end
                OP_TEXT: begin
                    if (r_pos >= PW'(TEXT_MAX)) begin
                        n_sat = 1'b1;
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                    if (match) begin
                        n_score = sat16(s);
                        n_last  = LW'(pos);
                        n_slot  = r_slot + CW'(1);
                    end
                    n_sep = is_sep(i_code_point);
                end
                OP_END: begin
                    res_en = 1'b1;
                    if (r_count == '0) begin
                        res_found = 1'b1;
                    end else if ((r_slot >= r_count) && (XW'(r_count) <= XW'(r_pos))) begin
                        res_found = 1'b1;
                        res_score = sat16(18'(r_score) - 18'(extra_q));
                    end
                end
                default: ;
            endcase
            // Restart the scan on clear and end of text
            if (op == OP_CLEAR || op == OP_END) begin
                n_slot  = '0;
                n_pos   = '0;
                n_last  = -LW'(2);
                n_score = 16'(SCORE_START);
                n_sep   = 1'b1;
                n_sat   = 1'b0;
            end
        end
    end

    // Query memory: write on append, prefetch the character at the next slot
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= i_code_point;
        end
        if (wr_en && (r_count == n_slot)) begin
            r_qchar <= i_code_point;
        end else begin
            r_qchar <= mem[n_slot[AW-1:0]];
        end
    end

    // Scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_slot  <= '0;
            r_pos   <= '0;
            r_last  <= -LW'(2);
            r_score <= 16'(SCORE_START);
            r_sep   <= 1'b1;
            r_sat   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_slot  <= n_slot;
            r_pos   <= n_pos;
            r_last  <= n_last;
            r_score <= n_score;
            r_sep   <= n_sep;
            r_sat   <= n_sat;
        end
    end

    // Output register with skid: hold while stalled, drain skid first
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (out_free) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= res_en;
            end
        end else if (res_en) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sk_valid) begin
                r_found  <= r_sk_found;
                r_oscore <= r_sk_score;
                r_ovf    <= r_sk_ovf;
            end else if (res_en) begin
                r_found  <= res_found;
                r_oscore <= res_score;
                r_ovf    <= r_sat;
            end
        end else if (res_en) begin
            r_sk_found <= res_found;
            r_sk_score <= res_score;
            r_sk_ovf   <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_score     = r_oscore;
    assign o_overflow  = r_ovf;

endmodule

FILE: tb/fuzzy_score_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the fuzzy subsequence scorer: follows accepted input words,
// keeps its own copy of the query and match state, and checks each result word.
// Depends on fss_pkg for the opcode type, scoring constants and separators.

module fuzzy_score_checker
    import fss_pkg::*;
#(
    parameter int QUERY_MAX = 512,
    parameter int TEXT_MAX  = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [20:0]        i_code_point,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_found,
    input  logic signed [15:0] i_score,
    input  logic               i_overflow,
    output int                 o_pending,
    output int                 o_fail_count
);

    typedef struct {
        logic               found;
        logic signed [15:0] score;
        logic               overflow;
    } t_score_word;

    // Query copy and scan state
    logic [20:0] query_chars [QUERY_MAX];
    int          query_len;
    int          matched_len;
    int          text_len;
    int          last_hit;
    int          running;
    logic        boundary;
    logic        clipped;

    t_score_word expected_scores [$];
    t_score_word want;
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int clip16(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic logic separator(input logic [20:0] c);
        return (c == CP_SPACE) || (c == CP_SLASH) || (c == CP_DASH) ||
               (c == CP_UNDER) || (c == CP_DOT);
    endfunction

    task automatic restart_text();
        matched_len = 0;
        text_len    = 0;
        last_hit    = -2;
        running     = SCORE_START;
        boundary    = 1'b1;
        clipped     = 1'b0;
    endtask

    // Compare one text character with the next unmatched query character
    task automatic take_char(input logic [20:0] c);
        int pos;
        int total;
        int gap;
        if (text_len >= TEXT_MAX) begin
            pos     = TEXT_MAX;
            clipped = 1'b1;
        end else begin
            pos = text_len;
            text_len++;
        end
        if (matched_len < query_len && query_chars[matched_len] == c) begin
            total = running;
            if (pos == last_hit + 1) begin
                total += BONUS_ADJ;
            end else begin
                gap = pos - last_hit - 1;
                if (gap < 0) gap = 0;
                if (gap > GAP_CAP) gap = GAP_CAP;
                total -= gap;
            end
            if (boundary) begin
                total += BONUS_BOUND;
            end
            if (matched_len == 0) begin
                total -= (pos > LEAD_CAP) ? LEAD_CAP : pos;
            end
            running  = clip16(total);
            last_hit = pos;
            matched_len++;
        end
        boundary = separator(c);
    endtask

    // Work out the result of one text and start over
    task automatic close_text();
        t_score_word r;
        int          extra;
        r.found    = 1'b0;
        r.score    = '0;
        r.overflow = clipped;
        if (query_len == 0) begin
            r.found = 1'b1;
        end else if (matched_len >= query_len && query_len <= text_len) begin
            extra = text_len - query_len;
            if (extra > EXTRA_CAP) extra = EXTRA_CAP;
            r.found = 1'b1;
            r.score = 16'(clip16(running - extra / 4));
        end
        expected_scores.push_back(r);
        restart_text();
    endtask

    task automatic track_word(input t_opcode op, input logic [20:0] c);
        case (op)
            OP_CLEAR: begin
                query_len = 0;
                restart_text();
            end
            OP_APPEND: begin
                if (query_len < QUERY_MAX) begin
                    query_chars[query_len] = c;
                    query_len++;
                end
            end
            OP_TEXT: begin
                take_char(c);
            end
            default: begin
                close_text();
            end
        endcase
    endtask

    // Check results first, then fold in the accepted input word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            query_len = 0;
            restart_text();
            expected_scores.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_scores.size() == 0) begin
                    $error("unexpected result word: found %0b score %0d overflow %0b",
                           i_found, i_score, i_overflow);
                    mismatches++;
                end else begin
                    want = expected_scores.pop_front();
                    if (i_found !== want.found) begin
                        $error("found: expected %0b, got %0b", want.found, i_found);
                        mismatches++;
                    end
                    if (i_score !== want.score) begin
                        $error("score: expected %0d, got %0d", want.score, i_score);
                        mismatches++;
                    end
                    if (i_overflow !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b", want.overflow, i_overflow);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                track_word(t_opcode'(i_opcode), i_code_point);
            end
        end
        o_pending <= expected_scores.size();
    end

endmodule

FILE: tb/tb_fuzzy_subsequence_score_top.sv
`timescale 1ns / 1ps
// Top of the fuzzy subsequence scorer testbench: clock, reset, input words and
// output stalls, and the verdict. Depends on fss_pkg, the scorer and fuzzy_score_checker.

module tb_fuzzy_subsequence_score_top;
    import fss_pkg::*;

    localparam int          QUERY_MAX = 512;
    localparam int          TEXT_MAX  = 4096;
    localparam int          PHASE_WORDS = 110;
    localparam int          LONG_RUN    = 100;
    localparam logic [20:0] CP_TOP = 21'h10FFFF;
    localparam logic [20:0] CH_A   = 21'h61;
    localparam logic [20:0] CH_B   = 21'h62;
    localparam logic [20:0] CH_X   = 21'h78;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    t_opcode            opcode     = OP_CLEAR;
    logic [20:0]        code_point = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic               found;
    logic signed [15:0] score;
    logic               overflow;

    int pending;
    int fail_count;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int words_sent = 0;

    fuzzy_subsequence_score_top #(
        .QUERY_MAX (QUERY_MAX),
        .TEXT_MAX  (TEXT_MAX)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_code_point (code_point),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_found      (found),
        .o_score      (score),
        .o_overflow   (overflow)
    );

    fuzzy_score_checker #(
        .QUERY_MAX (QUERY_MAX),
        .TEXT_MAX  (TEXT_MAX)
    ) scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_code_point (code_point),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_found      (found),
        .i_score      (score),
        .i_overflow   (overflow),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Hold a word on the input until it is accepted, with random gaps before it
    task automatic send_word(input t_opcode op, input logic [20:0] cp);
        while ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        code_point <= cp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Drop valid and wait until every result has come back
    task automatic await_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Mostly a small alphabet so matches happen, plus separators and wild values
    function automatic logic [20:0] pick_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return CH_A + 21'(r % 4);
        end
        case (r)
            12: return CP_SPACE;
            13: return CP_SLASH;
            14: return CP_DASH;
            15: return CP_UNDER;
            16: return CP_DOT;
            default: return 21'($urandom_range(0, CP_TOP));
        endcase
    endfunction

    // One candidate text against a small query, or a burst of random words
    task automatic random_sequence();
        int qlen;
        int tlen;
        int k;
        if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 1) == 1) begin
                send_word(OP_CLEAR, 21'($urandom_range(0, CP_TOP)));
                qlen = $urandom_range(0, 5);
            end else begin
                qlen = $urandom_range(0, 2);
            end
            for (k = 0; k < qlen; k++) begin
                send_word(OP_APPEND, pick_char());
            end
            tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 14);
            for (k = 0; k < tlen; k++) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_word(OP_APPEND, pick_char());
                end
                send_word(OP_TEXT, pick_char());
            end
            send_word(OP_END, 21'($urandom_range(0, CP_TOP)));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                send_word(t_opcode'($urandom_range(0, 3)), 21'($urandom_range(0, CP_TOP)));
            end
        end
    endtask

    initial begin
        int          k;
        int          goal;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 0: sender gaps 34%, receiver stalls 50%
        gap_pct   = 34;
        stall_pct = 50;

        // empty query scores zero
        send_word(OP_END, CP_TOP);
        // query "ab" against "x_ab": boundary bonus, then an adjacent match
        send_word(OP_APPEND, CH_A);
        send_word(OP_APPEND, CH_B);
        send_word(OP_TEXT, CH_X);
        send_word(OP_TEXT, CP_UNDER);
        send_word(OP_TEXT, CH_A);
        send_word(OP_TEXT, CH_B);
        send_word(OP_END, '0);
        // incomplete match
        send_word(OP_TEXT, CH_B);
        send_word(OP_END, '0);
        // text shorter than the query
        send_word(OP_TEXT, CH_A);
        send_word(OP_END, '0);
        // append while a text is running
        send_word(OP_CLEAR, CP_TOP);
        send_word(OP_APPEND, CH_X);
        send_word(OP_TEXT, CH_X);
        send_word(OP_APPEND, CH_A);
        send_word(OP_TEXT, CP_DOT);
        send_word(OP_TEXT, CH_A);
        send_word(OP_END, '0);
        // extreme code points
        send_word(OP_CLEAR, '0);
        send_word(OP_APPEND, CP_TOP);
        send_word(OP_APPEND, '0);
        send_word(OP_TEXT, CP_TOP);
        send_word(OP_TEXT, '0);
        send_word(OP_END, CP_TOP);
        send_word(OP_CLEAR, '0);

        goal = words_sent + PHASE_WORDS;
        while (words_sent < goal) random_sequence();
        await_results();

        // Phase 1: sender gaps 50%, receiver stalls 34%
        gap_pct   = 50;
        stall_pct = 34;

        // first match lands past the lead cap, text stays just under the extra-length cap
        send_word(OP_CLEAR, '0);
        repeat (6) send_word(OP_APPEND, CH_A);
        for (k = 0; k < LONG_RUN; k++) begin
            send_word(OP_TEXT, CH_B + 21'($urandom_range(0, 2)));
        end
        repeat (24) send_word(OP_TEXT, CH_A);
        send_word(OP_END, '0);
        send_word(OP_CLEAR, '0);

        goal = words_sent + PHASE_WORDS;
        while (words_sent < goal) random_sequence();
        await_results();

        // Phase 2: no gaps, no stalls
        gap_pct   = 0;
        stall_pct = 0;
        goal = words_sent + PHASE_WORDS;
        while (words_sent < goal) random_sequence();
        await_results();
        repeat (8) @(posedge clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
hdl/fss_pkg.sv
hdl/fuzzy_subsequence_score_top.sv
tb/fuzzy_score_checker.sv
tb/tb_fuzzy_subsequence_score_top.sv
